### src/mdc_pkg.sv
// ---------------------------------------------------------------------------
// mdc_pkg: shared types and constants for the move duration block
// Fixed-point constants, register indexes and the per-move side record.
// ---------------------------------------------------------------------------
`default_nettype none

package mdc_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_TURNTABLE = 2'd0;
    localparam logic [1:0] CFG_RADIAL    = 2'd1;
    localparam logic [1:0] CFG_LIFT      = 2'd2;

    localparam int CAP_W  = 20;
    localparam int QUO_W  = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CAP_W-1:0] TURNTABLE_CAP_RST = 20'd90000;
    localparam logic [CAP_W-1:0] RADIAL_CAP_RST    = 20'd100000;
    localparam logic [CAP_W-1:0] LIFT_CAP_RST      = 20'd20000;

    // arc = round(da * s * pi / 360000), pi in Q24
    localparam logic [18:0] DEG_DIV  = 19'd360000;
    localparam logic [25:0] PI_Q24   = 26'd52707179;
    // floor(2^53 / 360000) and floor(2^45 / 360000)
    localparam logic [34:0] RECIP_A  = 35'd25019997929;
    localparam int          RECIP_A_SH = 53;
    localparam logic [26:0] RECIP_B  = 27'd97734366;
    localparam int          RECIP_B_SH = 45;
    localparam logic [23:0] HALF_Q24 = 24'd8388608;
    localparam logic [21:0] MIN_RSUM = 22'd2000;

    localparam logic [15:0] FEED_SCALE = 16'd60000;
    localparam logic [9:0]  SLOW_SCALE = 10'd1000;
    localparam logic [19:0] US_SCALE   = 20'd1000000;

    // square root steps and total pipeline depth up to the result stage
    localparam int ROOT_STEPS = 32;
    localparam int ROOT_BASE  = 13;
    localparam int PIPE_LAT   = 82;

    typedef struct packed {
        logic [31:0]        da;
        logic [20:0]        dr;
        logic [20:0]        dh;
        logic signed [15:0] feed;
        logic               sat;
        logic               zero;
    } trk_t;

endpackage

`default_nettype wire

### src/mdc_div.sv
// ---------------------------------------------------------------------------
// mdc_div: pipelined 32-bit quotient divider with overflow detect
// One quotient bit per stage; flags quotients of 2^32 or more.
// ---------------------------------------------------------------------------
`default_nettype none

module mdc_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 20
) (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire logic [NUM_W-1:0]           num,
    input  wire logic [DEN_W-1:0]           den,
    output logic [mdc_pkg::QUO_W-1:0]       quo,
    output logic                            ovf
);

    localparam int QW = mdc_pkg::QUO_W;
    localparam int HW = NUM_W - QW;
    localparam int CW = (HW > DEN_W) ? HW : DEN_W;

    logic [DEN_W-1:0] rem_reg [0:QW];
    logic [QW-1:0]    low_reg [0:QW];
    logic [QW-1:0]    quo_reg [0:QW];
    logic [DEN_W-1:0] den_reg [0:QW];
    logic             ovf_reg [0:QW];

    logic [DEN_W:0]   trial [1:QW];
    logic             take  [1:QW];

    always_comb begin
        for (int k = 1; k <= QW; k++) begin
            trial[k] = {rem_reg[k-1], low_reg[k-1][QW-1]};
            take[k]  = trial[k] >= {1'b0, den_reg[k-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // high part below the divisor means the quotient fits in 32 bits
            rem_reg[0] <= DEN_W'(num >> QW);
            low_reg[0] <= num[QW-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            ovf_reg[0] <= CW'(num >> QW) >= CW'(den);
            for (int k = 1; k <= QW; k++) begin
                rem_reg[k] <= take[k] ? DEN_W'(trial[k] - {1'b0, den_reg[k-1]})
                                      : trial[k][DEN_W-1:0];
                low_reg[k] <= {low_reg[k-1][QW-2:0], 1'b0};
                quo_reg[k] <= {quo_reg[k-1][QW-2:0], take[k]};
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quo = quo_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

`default_nettype wire

### src/move_duration_with_axis_caps.sv
// ---------------------------------------------------------------------------
// move_duration_with_axis_caps: move time under feed and per-axis ceilings
// Arc at mean radius, eyelet path length, feed time and axis times, max.
// ---------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  s_*       in         s_valid / s_ready       start/end pose, feed
//  m_*       out        m_valid / m_ready       move_time_us, time_saturated
//  cfg_*     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  one move per cycle while s_ready is high; new moves enter before earlier ones finish
//  depth set by the 32-step root stages and the 32-stage dividers
//  reset clears valid bits and loads the default ceilings
//  a stalled output holds one result in a skid register; s_ready drops
//  only when that skid register is full, and the whole pipe then freezes
// ---------------------------------------------------------------------------
`default_nettype none

module move_duration_with_axis_caps (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic signed [31:0]  s_start_angle,
    input  wire logic signed [20:0]  s_start_radius,
    input  wire logic signed [20:0]  s_start_height,
    input  wire logic signed [31:0]  s_end_angle,
    input  wire logic signed [20:0]  s_end_radius,
    input  wire logic signed [20:0]  s_end_height,
    input  wire logic signed [15:0]  s_feed_mm_per_min,

    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [31:0]              m_move_time_us,
    output logic                     m_time_saturated,

    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [mdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [19:0]         cfg_data
);

    localparam int LAT = mdc_pkg::PIPE_LAT;
    localparam int RB  = mdc_pkg::ROOT_BASE;
    localparam int RS  = mdc_pkg::ROOT_STEPS;
    localparam int ARC_STG = 11;

    // configuration
    logic [19:0] cap_t_reg, cap_r_reg, cap_h_reg;
    logic [19:0] cap_t, cap_r, cap_h;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_t_reg <= mdc_pkg::TURNTABLE_CAP_RST;
            cap_r_reg <= mdc_pkg::RADIAL_CAP_RST;
            cap_h_reg <= mdc_pkg::LIFT_CAP_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mdc_pkg::CFG_TURNTABLE: cap_t_reg <= cfg_data;
                mdc_pkg::CFG_RADIAL:    cap_r_reg <= cfg_data;
                mdc_pkg::CFG_LIFT:      cap_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // a zero ceiling counts as one
    assign cap_t = (cap_t_reg == '0) ? 20'd1 : cap_t_reg;
    assign cap_r = (cap_r_reg == '0) ? 20'd1 : cap_r_reg;
    assign cap_h = (cap_h_reg == '0) ? 20'd1 : cap_h_reg;

    // pipeline control
    logic adv;
    logic vld_reg [1:LAT];
    mdc_pkg::trk_t trk_reg [1:LAT];

    // stage 1: travel and clamped radius sum
    logic [32:0] adiff;
    logic [21:0] rdiff, hdiff, rsum;
    logic [31:0] da_c;
    logic [20:0] dr_c, dh_c, rs_c;

    always_comb begin
        adiff = {s_end_angle[31], s_end_angle} - {s_start_angle[31], s_start_angle};
        rdiff = {s_end_radius[20], s_end_radius} - {s_start_radius[20], s_start_radius};
        hdiff = {s_end_height[20], s_end_height} - {s_start_height[20], s_start_height};
        rsum  = {s_end_radius[20], s_end_radius} + {s_start_radius[20], s_start_radius};
        da_c  = adiff[32] ? 32'(~adiff + 33'd1) : adiff[31:0];
        dr_c  = rdiff[21] ? 21'(~rdiff + 22'd1) : rdiff[20:0];
        dh_c  = hdiff[21] ? 21'(~hdiff + 22'd1) : hdiff[20:0];
        rs_c  = ($signed(rsum) < $signed(mdc_pkg::MIN_RSUM)) ? 21'(mdc_pkg::MIN_RSUM)
                                                            : rsum[20:0];
    end

    logic [20:0] rs1_reg;
    logic [52:0] prod2_reg, prod3_reg, prod4_reg, prod5_reg;
    logic [66:0] mlo3_reg;
    logic [55:0] mhi3_reg;
    logic [34:0] qe4_reg, qe5_reg, q6_reg;
    logic [52:0] qd5_reg;
    logic [18:0] rem6_reg;
    logic [60:0] a7_reg, a8_reg, a9_reg, a10_reg;
    logic [44:0] b7_reg, b8_reg, b9_reg;
    logic [71:0] bm8_reg;
    logic [26:0] e9_reg, f10_reg;
    logic [44:0] ed9_reg;
    logic [31:0] arc11_reg;
    logic [63:0] sqa12_reg;
    logic [41:0] sqr12_reg, sqh12_reg;

    logic [87:0] qsum4;
    logic [52:0] r6_full;
    logic [19:0] r6;
    logic        fix6;
    logic        corr10;
    logic [61:0] aq11;
    logic [37:0] arc_c;
    logic [64:0] sum13;
    logic        sat13, zero13;
    mdc_pkg::trk_t trk_arc_c, trk_root_c;

    always_comb begin
        qsum4   = 88'(mlo3_reg) + {mhi3_reg, 32'd0};
        r6_full = prod5_reg - qd5_reg;
        r6      = r6_full[19:0];
        fix6    = r6 >= 20'(mdc_pkg::DEG_DIV);
        corr10  = (b9_reg - ed9_reg) >= 45'(mdc_pkg::DEG_DIV);
        aq11    = 62'(a10_reg) + 62'(f10_reg) + 62'(mdc_pkg::HALF_Q24);
        arc_c   = aq11[61:24];
        sum13   = 65'(sqa12_reg) + 65'(sqr12_reg) + 65'(sqh12_reg);
        sat13   = trk_reg[RB-1].sat | sum13[64];
        zero13  = !sat13 && (sum13[63:0] == '0);
        // side record with the arc overflow and the length checks folded in
        trk_arc_c      = trk_reg[ARC_STG-1];
        trk_arc_c.sat  = trk_reg[ARC_STG-1].sat | (|arc_c[37:32]);
        trk_root_c      = trk_reg[RB-1];
        trk_root_c.sat  = sat13;
        trk_root_c.zero = zero13;
    end

    // square root, two bits per stage
    logic [33:0] sq_rem_reg  [0:RS];
    logic [31:0] sq_root_reg [0:RS];
    logic [63:0] sq_n_reg    [0:RS];
    logic [35:0] sq_cur [1:RS];
    logic [35:0] sq_trl [1:RS];
    logic        sq_tk  [1:RS];

    always_comb begin
        for (int k = 1; k <= RS; k++) begin
            sq_cur[k] = {sq_rem_reg[k-1], sq_n_reg[k-1][63:62]};
            sq_trl[k] = 36'({sq_root_reg[k-1], 2'b01});
            sq_tk[k]  = sq_cur[k] >= sq_trl[k];
        end
    end

    logic [32:0] len46_reg;
    logic [47:0] nf47_reg;
    logic [14:0] df47_reg;
    logic [51:0] na47_reg;
    logic [40:0] nr47_reg, nh47_reg;

    logic [31:0] qf, qa, qr, qh;
    logic        of, oa, orr, oh;
    logic [31:0] mx81a_reg, mx81b_reg;
    logic        ovf81_reg;
    logic [31:0] res_time_reg;
    logic        res_sat_reg;
    logic [31:0] mx_c;

    assign mx_c = (mx81a_reg > mx81b_reg) ? mx81a_reg : mx81b_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            trk_reg[1] <= '{da: da_c, dr: dr_c, dh: dh_c, feed: s_feed_mm_per_min,
                            sat: 1'b0, zero: 1'b0};
            rs1_reg    <= rs_c;
            for (int k = 2; k <= LAT; k++) begin
                if (k == ARC_STG) begin
                    trk_reg[k] <= trk_arc_c;
                end else if (k == RB) begin
                    trk_reg[k] <= trk_root_c;
                end else begin
                    trk_reg[k] <= trk_reg[k-1];
                end
            end

            prod2_reg <= 53'(trk_reg[1].da) * 53'(rs1_reg);
            // quotient estimate by 360000, low by at most one
            mlo3_reg  <= 67'(prod2_reg[31:0]) * 67'(mdc_pkg::RECIP_A);
            mhi3_reg  <= 56'(prod2_reg[52:32]) * 56'(mdc_pkg::RECIP_A);
            prod3_reg <= prod2_reg;
            qe4_reg   <= 35'(qsum4 >> mdc_pkg::RECIP_A_SH);
            prod4_reg <= prod3_reg;
            qd5_reg   <= 53'(qe4_reg) * 53'(mdc_pkg::DEG_DIV);
            qe5_reg   <= qe4_reg;
            prod5_reg <= prod4_reg;
            q6_reg    <= qe5_reg + 35'(fix6);
            rem6_reg  <= fix6 ? 19'(r6 - 20'(mdc_pkg::DEG_DIV)) : r6[18:0];
            a7_reg    <= 61'(q6_reg) * 61'(mdc_pkg::PI_Q24);
            b7_reg    <= 45'(rem6_reg) * 45'(mdc_pkg::PI_Q24);
            bm8_reg   <= 72'(b7_reg) * 72'(mdc_pkg::RECIP_B);
            a8_reg    <= a7_reg;
            b8_reg    <= b7_reg;
            e9_reg    <= bm8_reg[71:mdc_pkg::RECIP_B_SH];
            ed9_reg   <= 45'(46'(bm8_reg[71:mdc_pkg::RECIP_B_SH]) * 46'(mdc_pkg::DEG_DIV));
            a9_reg    <= a8_reg;
            b9_reg    <= b8_reg;
            f10_reg   <= e9_reg + 27'(corr10);
            a10_reg   <= a9_reg;
            arc11_reg <= arc_c[31:0];
            sqa12_reg <= 64'(arc11_reg) * 64'(arc11_reg);
            sqr12_reg <= 42'(trk_reg[ARC_STG].dr) * 42'(trk_reg[ARC_STG].dr);
            sqh12_reg <= 42'(trk_reg[ARC_STG].dh) * 42'(trk_reg[ARC_STG].dh);

            sq_n_reg[0]    <= sum13[63:0];
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            for (int k = 1; k <= RS; k++) begin
                sq_n_reg[k]    <= {sq_n_reg[k-1][61:0], 2'b00};
                sq_rem_reg[k]  <= sq_tk[k] ? 34'(sq_cur[k] - sq_trl[k]) : sq_cur[k][33:0];
                sq_root_reg[k] <= {sq_root_reg[k-1][30:0], sq_tk[k]};
            end

            // round to nearest: remainder above the floor root
            len46_reg <= 33'(sq_root_reg[RS])
                       + 33'(sq_rem_reg[RS] > 34'(sq_root_reg[RS]));

            if (trk_reg[RB+RS+1].feed <= 16'sd0) begin
                nf47_reg <= 48'(len46_reg) * 48'(mdc_pkg::SLOW_SCALE);
                df47_reg <= 15'd1;
            end else begin
                nf47_reg <= 48'(len46_reg) * 48'(mdc_pkg::FEED_SCALE)
                          + 48'(trk_reg[RB+RS+1].feed[14:1]);
                df47_reg <= trk_reg[RB+RS+1].feed[14:0];
            end
            na47_reg <= 52'(trk_reg[RB+RS+1].da) * 52'(mdc_pkg::US_SCALE) + 52'(cap_t[19:1]);
            nr47_reg <= 41'(trk_reg[RB+RS+1].dr) * 41'(mdc_pkg::US_SCALE) + 41'(cap_r[19:1]);
            nh47_reg <= 41'(trk_reg[RB+RS+1].dh) * 41'(mdc_pkg::US_SCALE) + 41'(cap_h[19:1]);

            mx81a_reg <= (qf > qa) ? qf : qa;
            mx81b_reg <= (qr > qh) ? qr : qh;
            ovf81_reg <= of | oa | orr | oh;

            if (trk_reg[LAT-1].zero) begin
                res_time_reg <= '0;
                res_sat_reg  <= 1'b0;
            end else if (trk_reg[LAT-1].sat || ovf81_reg) begin
                res_time_reg <= '1;
                res_sat_reg  <= 1'b1;
            end else begin
                res_time_reg <= mx_c;
                res_sat_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[1] <= s_valid;
            for (int k = 2; k <= LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    mdc_div #(.NUM_W(48), .DEN_W(15)) u_div_feed (
        .aclk(aclk), .en(adv), .num(nf47_reg), .den(df47_reg), .quo(qf), .ovf(of)
    );

    mdc_div #(.NUM_W(52), .DEN_W(20)) u_div_turn (
        .aclk(aclk), .en(adv), .num(na47_reg), .den(cap_t), .quo(qa), .ovf(oa)
    );

    mdc_div #(.NUM_W(41), .DEN_W(20)) u_div_rad (
        .aclk(aclk), .en(adv), .num(nr47_reg), .den(cap_r), .quo(qr), .ovf(orr)
    );

    mdc_div #(.NUM_W(41), .DEN_W(20)) u_div_lift (
        .aclk(aclk), .en(adv), .num(nh47_reg), .den(cap_h), .quo(qh), .ovf(oh)
    );

    // output register with skid
    logic        out_vld_reg, skid_vld_reg;
    logic [31:0] out_time_reg, skid_time_reg;
    logic        out_sat_reg, skid_sat_reg;
    logic        p_fire, out_free;

    assign adv      = !skid_vld_reg;
    assign s_ready  = adv;
    assign p_fire   = adv && vld_reg[LAT];
    assign out_free = !out_vld_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_vld_reg) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg <= p_fire;
            end
        end else if (p_fire) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_vld_reg) begin
                out_time_reg <= skid_time_reg;
                out_sat_reg  <= skid_sat_reg;
            end else if (p_fire) begin
                out_time_reg <= res_time_reg;
                out_sat_reg  <= res_sat_reg;
            end
        end else if (p_fire) begin
            skid_time_reg <= res_time_reg;
            skid_sat_reg  <= res_sat_reg;
        end
    end

    assign m_valid          = out_vld_reg;
    assign m_move_time_us   = out_time_reg;
    assign m_time_saturated = out_sat_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds a result while output is empty");

    a_skid_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg && !(m_valid && m_ready) |=> skid_vld_reg)
        else $error("skid result dropped while output stalled");

    a_sat_full: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_sat_reg |-> out_time_reg == 32'hFFFF_FFFF)
        else $error("saturated result without full-scale time");

    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> vld_reg[LAT] == $past(vld_reg[LAT]))
        else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
